FILE: hw/rtl/std_pkg.sv
package std_pkg;

  localparam int unsigned TaskW = 11;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_REQUEST = 2'd1,
    OP_FOUND   = 2'd2,
    OP_UNUSED  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_READY   = 3'd0,
    KIND_ASSIGN  = 3'd1,
    KIND_NO_MORE = 3'd2,
    KIND_STOP    = 3'd3,
    KIND_FOUND   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    REG_MODE    = 2'd0,
    REG_SEED    = 2'd1,
    REG_STOP1ST = 2'd2,
    REG_WORKERS = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  requester;
    logic [63:0] found_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       destination;
    logic [TaskW-1:0] task_id;
    logic [63:0]      reported_index;
    logic             all_done;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_DRAW,
    ST_MIX1,
    ST_MIX1B,
    ST_MIX2,
    ST_MIX2B,
    ST_MIX3,
    ST_DIV,
    ST_RD,
    ST_SWAP,
    ST_REQ,
    ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture request, init counters
    logic fill_clr;   // index := 0
    logic fill_step;  // write table[idx]=idx, idx++
    logic draw;       // advance generator
    logic mix1;       // partial products of first mix step
    logic mix2;       // partial products of second mix step
    logic mix_sum;    // combine partial products into z
    logic div_start;  // start modulo
    logic rd;         // read table[i] and table[j]
    logic swap;       // write back, i--
    logic req_rd;     // read table at position
    logic finish;     // build result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic fill_last;
    logic div_done;
    logic shuf_last;
  } sts_t;

endpackage

FILE: hw/rtl/std_ctrl.sv
module std_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  logic [1:0]    op,
  input  logic          mode,
  output std_pkg::cmd_t cmd,
  input  std_pkg::sts_t sts
);
  import std_pkg::*;

  state_t state, state_next;
  logic   hold, hold_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      hold  <= 1'b0;
    end else begin
      state <= state_next;
      hold  <= hold_next;
    end
  end

  // a finished result waits in the output register while idle accepts the next
  assign out_valid = hold;
  assign in_stall  = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    hold_next  = hold && out_stall;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load = 1'b1;
          unique case (op_t'(op))
            OP_START:   state_next = mode ? ST_FILL : ST_OUT;
            OP_REQUEST: state_next = ST_REQ;
            OP_FOUND:   state_next = ST_OUT;
            default:    state_next = ST_IDLE;
          endcase
          cmd.fill_clr = 1'b1;
        end
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_last) state_next = ST_DRAW;
      end
      ST_DRAW:  begin cmd.draw = 1'b1; state_next = ST_MIX1; end
      ST_MIX1:  begin cmd.mix1 = 1'b1; state_next = ST_MIX1B; end
      ST_MIX1B: begin cmd.mix_sum = 1'b1; state_next = ST_MIX2; end
      ST_MIX2:  begin cmd.mix2 = 1'b1; state_next = ST_MIX2B; end
      ST_MIX2B: begin cmd.mix_sum = 1'b1; state_next = ST_MIX3; end
      ST_MIX3:  begin cmd.div_start = 1'b1; state_next = ST_DIV; end
      ST_DIV:   if (sts.div_done) state_next = ST_RD;
      ST_RD:    begin cmd.rd = 1'b1; state_next = ST_SWAP; end
      ST_SWAP: begin
        cmd.swap = 1'b1;
        state_next = sts.shuf_last ? ST_OUT : ST_DRAW;
      end
      ST_REQ:  begin cmd.req_rd = 1'b1; state_next = ST_OUT; end
      ST_OUT: begin
        if (!hold) begin
          cmd.finish = 1'b1;
          hold_next  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

FILE: hw/rtl/std_datapath.sv
module std_datapath #(
  parameter int unsigned NUM_TASKS = 1296
) (
  input  logic                clk,
  input  logic                rst,
  input  std_pkg::in_item_t   in_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  input  std_pkg::cmd_t       cmd,
  output std_pkg::sts_t       sts,
  output logic                mode,
  output std_pkg::out_item_t  out_item
);
  import std_pkg::*;

  localparam int unsigned PW = $clog2(NUM_TASKS + 1);
  localparam int unsigned AW = $clog2(NUM_TASKS);
  localparam logic [PW-1:0] LastPos = PW'(NUM_TASKS - 1);
  localparam logic [PW-1:0] NumPos  = PW'(NUM_TASKS);
  localparam logic [63:0]   Mix1K   = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0]   Mix2K   = 64'h94D049BB133111EB;

  logic        stop_first;
  logic [63:0] seed;
  logic [7:0]  worker_count;

  logic [1:0]  op;
  logic [7:0]  req;
  logic [63:0] found;

  logic [PW-1:0] position;
  logic [63:0]   gen;
  logic          stop_sent;
  logic [7:0]    workers_left;

  logic [AW-1:0] table_mem [NUM_TASKS];
  logic [PW-1:0] idx;      // fill index / shuffle i
  logic [63:0]   z;
  logic [PW-1:0] j;
  logic [AW-1:0] ti, tj;

  // 64-bit product mod 2^64 from 32x32 partial products, summed next cycle
  logic [63:0] mx, mk, p_ll;
  logic [31:0] p_lh, p_hl;
  logic [63:0] prod_lo;
  logic [31:0] prod_x;

  // restoring modulo: 64-bit z ^ (z >> 31) by (i+1), one bit per cycle
  logic [PW:0]   rem;
  logic [63:0]   quo_sh;
  logic [6:0]    div_cnt;
  logic          div_busy;
  logic [PW:0]   rem_sh;
  logic [PW:0]   dvs;

  assign dvs    = {1'b0, idx} + 1'b1;
  assign rem_sh = {rem[PW-1:0], quo_sh[63]};

  assign mx   = cmd.mix2 ? (z ^ (z >> 27)) : (z ^ (z >> 30));
  assign mk   = cmd.mix2 ? Mix2K : Mix1K;
  assign p_ll = 64'(mx[31:0]) * 64'(mk[31:0]);
  assign p_lh = mx[31:0] * mk[63:32];
  assign p_hl = mx[63:32] * mk[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= 1'b0;
      seed       <= 64'd42;
      stop_first <= 1'b1;
      worker_count <= 8'd3;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MODE:    mode         <= cfg_data[0];
        REG_SEED:    seed         <= cfg_data;
        REG_STOP1ST: stop_first   <= cfg_data[0];
        REG_WORKERS: worker_count <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= '0;
      gen          <= '0;
      stop_sent    <= 1'b0;
      workers_left <= '0;
      div_busy     <= 1'b0;
    end else begin
      if (cmd.load) begin
        op    <= in_item.operation;
        req   <= in_item.requester;
        found <= in_item.found_index;
        if (op_t'(in_item.operation) == OP_START) begin
          position     <= '0;
          stop_sent    <= 1'b0;
          workers_left <= worker_count;
          gen          <= (seed == 64'd0) ? 64'd1 : seed;
        end
      end
      if (cmd.fill_clr) idx <= '0;
      if (cmd.fill_step) begin
        table_mem[idx[AW-1:0]] <= idx[AW-1:0];
        idx <= (idx == LastPos) ? LastPos : idx + 1'b1;
      end
      if (cmd.draw) begin
        gen <= gen + 64'h9E3779B97F4A7C15;
        z   <= gen + 64'h9E3779B97F4A7C15;
      end
      if (cmd.mix1 || cmd.mix2) begin
        prod_lo <= p_ll;
        prod_x  <= p_lh + p_hl;
      end
      if (cmd.mix_sum) z <= prod_lo + {prod_x, 32'd0};
      if (cmd.div_start) begin
        quo_sh   <= z ^ (z >> 31);
        rem      <= '0;
        div_cnt  <= '0;
        div_busy <= 1'b1;
      end else if (div_busy) begin
        rem     <= (rem_sh >= dvs) ? rem_sh - dvs : rem_sh;
        quo_sh  <= quo_sh << 1;
        div_cnt <= div_cnt + 1'b1;
        if (div_cnt == 7'd63) div_busy <= 1'b0;
      end
      if (cmd.rd) begin
        ti <= table_mem[idx[AW-1:0]];
        j  <= rem[PW-1:0];
      end
      // second read port: swap partner while shuffling, position on a request
      if (cmd.rd || cmd.req_rd)
        tj <= table_mem[cmd.req_rd ? position[AW-1:0] : rem[AW-1:0]];
      if (cmd.swap) begin
        table_mem[idx[AW-1:0]] <= tj;
        table_mem[j[AW-1:0]]   <= ti;
        idx <= idx - 1'b1;
      end
      if (cmd.finish) begin
        out_item.destination    <= req;
        out_item.task_id        <= '0;
        out_item.reported_index <= '0;
        unique case (op_t'(op))
          OP_START: begin
            out_item.kind     <= KIND_READY;
            out_item.all_done <= (workers_left == 8'd0);
          end
          OP_REQUEST: begin
            if (stop_sent || position >= NumPos) begin
              out_item.kind <= KIND_NO_MORE;
              if (workers_left != 8'd0) workers_left <= workers_left - 1'b1;
              out_item.all_done <= (workers_left <= 8'd1);
            end else begin
              out_item.kind     <= KIND_ASSIGN;
              out_item.task_id  <= mode ? TaskW'(tj) : TaskW'(position);
              position          <= position + 1'b1;
              out_item.all_done <= (workers_left == 8'd0);
            end
          end
          default: begin
            out_item.reported_index <= found;
            out_item.all_done       <= (workers_left == 8'd0);
            if (stop_first && !stop_sent) begin
              stop_sent     <= 1'b1;
              out_item.kind <= KIND_STOP;
            end else begin
              out_item.kind <= KIND_FOUND;
            end
          end
        endcase
      end
    end
  end

  assign sts.fill_last = (idx == LastPos);
  assign sts.div_done  = !div_busy && !cmd.div_start;
  assign sts.shuf_last = (idx == PW'(1));
endmodule

FILE: hw/rtl/shuffled_task_dispenser_top.sv
// channel  | valid     | stall     | payload
// in       | in_valid  | in_stall  | in_item  (operation, requester, found_index)
// out      | out_valid | out_stall | out_item (kind, destination, task_id, ...)
// Found report, contiguous start: the accepted request goes to ST_OUT, which builds
// the result; a work request first passes ST_REQ for the table read.
// Start in shuffle mode: all NUM_TASKS entries are filled, then each of the
// NUM_TASKS-1 swaps draws, mixes and waits on the one-bit-per-cycle modulo unit.
// rst is synchronous; it restores register defaults and clears counters.
// A held result waits for out_stall low; idle still accepts the next request.
module shuffled_task_dispenser_top #(
  parameter int unsigned NUM_TASKS = 1296
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  std_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output std_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import std_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic mode;

  std_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .op(in_item.operation), .mode, .cmd, .sts
  );

  std_datapath #(.NUM_TASKS(NUM_TASKS)) u_dp (
    .clk, .rst, .in_item, .cfg_we, .cfg_index, .cfg_data, .cmd, .sts, .mode, .out_item
  );
endmodule

FILE: hw/rtl/std_checker.sv
module std_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input std_pkg::out_item_t out_item
);
  import std_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid)
    else $error("stalled request dropped");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("held result changed");

  a_task_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind != KIND_ASSIGN |-> out_item.task_id == '0)
    else $error("task id set on non-assignment");

  a_idx_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind != KIND_STOP && out_item.kind != KIND_FOUND
    |-> out_item.reported_index == 64'd0)
    else $error("index set on wrong kind");

  a_kind_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.kind <= KIND_FOUND)
    else $error("bad kind");
endmodule

bind shuffled_task_dispenser_top std_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .out_item
);

FILE: verif/tb_top.sv
module tb_top;
  import std_pkg::*;

  localparam int unsigned NumTasks = 1296;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_MODE;
  logic [63:0] cfg_data = '0;

  shuffled_task_dispenser_top #(.NUM_TASKS(NumTasks)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // dispenser shadow: registers and state
  logic        sh_mode;
  logic [63:0] sh_seed;
  logic        sh_stop_first;
  logic [7:0]  sh_workers;
  logic [TaskW-1:0] order_tbl [NumTasks];
  int unsigned next_pos;
  logic [63:0] mix_state;
  logic        stop_sent;
  int unsigned workers_left;

  in_item_t  pending_requests[$];
  out_item_t expected_results[$];
  int        mismatches = 0;
  bit        calm = 1'b0;
  int        in_gap = 0;
  int        out_gap = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [63:0] splitmix_next();
    logic [63:0] z;
    mix_state = mix_state + 64'h9E3779B97F4A7C15;
    z = mix_state;
    z = (z ^ (z >> 30)) * 64'hBF58476D1CE4E5B9;
    z = (z ^ (z >> 27)) * 64'h94D049BB133111EB;
    return z ^ (z >> 31);
  endfunction

  function automatic void shuffle_order();
    int unsigned j;
    logic [TaskW-1:0] t;
    for (int unsigned i = 0; i < NumTasks; i++) order_tbl[i] = TaskW'(i);
    for (int unsigned i = NumTasks - 1; i > 0; i--) begin
      j = int'(splitmix_next() % 64'(i + 1));
      t = order_tbl[i];
      order_tbl[i] = order_tbl[j];
      order_tbl[j] = t;
    end
  endfunction

  function automatic void predict_dispense(in_item_t it);
    out_item_t e;
    e = '0;
    e.destination = it.requester;
    case (op_t'(it.operation))
      OP_START: begin
        next_pos = 0;
        stop_sent = 1'b0;
        workers_left = sh_workers;
        mix_state = (sh_seed != 0) ? sh_seed : 64'd1;
        if (sh_mode) shuffle_order();
        e.kind = KIND_READY;
      end
      OP_REQUEST: begin
        if (stop_sent || next_pos >= NumTasks) begin
          e.kind = KIND_NO_MORE;
          if (workers_left > 0) workers_left--;
        end else begin
          e.kind = KIND_ASSIGN;
          e.task_id = sh_mode ? order_tbl[next_pos] : TaskW'(next_pos);
          next_pos++;
        end
      end
      OP_FOUND: begin
        e.reported_index = it.found_index;
        if (sh_stop_first && !stop_sent) begin
          stop_sent = 1'b1;
          e.kind = KIND_STOP;
        end else begin
          e.kind = KIND_FOUND;
        end
      end
      default: return;  // unused code: no result
    endcase
    e.all_done = (workers_left == 0);
    expected_results.push_back(e);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_dispense(in_item);
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          in_item <= pending_requests.pop_front();
          in_valid <= 1'b1;
          in_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and stall generator
  always @(posedge clk) begin
    out_item_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: kind %0d dest %0d", out_item.kind,
                     out_item.destination);
        end else begin
          e = expected_results.pop_front();
          if (out_item.kind !== e.kind || out_item.destination !== e.destination ||
              out_item.task_id !== e.task_id ||
              out_item.reported_index !== e.reported_index ||
              out_item.all_done !== e.all_done) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp kind %0d dest %0d task %0d idx %h done %0b",
                       e.kind, e.destination, e.task_id, e.reported_index, e.all_done,
                       " / got kind %0d dest %0d task %0d idx %h done %0b",
                       out_item.kind, out_item.destination, out_item.task_id,
                       out_item.reported_index, out_item.all_done);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_gap = pick_gap();
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_request(op_t op, logic [7:0] who, logic [63:0] idx);
    in_item_t it;
    it.operation = op;
    it.requester = who;
    it.found_index = idx;
    @(negedge clk);
    pending_requests.push_back(it);
  endtask

  task automatic push_random(int n, int start_pct, int found_pct);
    int r;
    op_t op;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < start_pct) op = OP_START;
      else if (r < start_pct + found_pct) op = OP_FOUND;
      else if (r < start_pct + found_pct + 2) op = OP_UNUSED;
      else op = OP_REQUEST;
      push_request(op, 8'($urandom_range(1, 255)), {$urandom(), $urandom()});
    end
  endtask

  task automatic write_reg(reg_idx_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_MODE: sh_mode = val[0];
      REG_SEED: sh_seed = val;
      REG_STOP1ST: sh_stop_first = val[0];
      default: sh_workers = val[7:0];
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every request went in and every result came back
  task automatic drain();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    sh_mode = 1'b0;
    sh_seed = 64'd42;
    sh_stop_first = 1'b1;
    sh_workers = 8'd3;
    next_pos = 0;
    mix_state = '0;
    stop_sent = 1'b0;
    workers_left = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // defaults, requests before any start, then a full stop sequence
    calm = 1'b1;
    push_request(OP_REQUEST, 8'd1, '0);
    push_request(OP_UNUSED, 8'd7, 64'hFFFF_FFFF_FFFF_FFFF);
    push_request(OP_REQUEST, 8'd255, '0);
    push_request(OP_START, 8'd255, '0);
    push_request(OP_REQUEST, 8'd2, '0);
    push_request(OP_REQUEST, 8'd3, '0);
    push_request(OP_FOUND, 8'd1, 64'hFFFF_FFFF_FFFF_FFFF);
    push_request(OP_FOUND, 8'd2, '0);
    push_request(OP_REQUEST, 8'd1, '0);
    push_request(OP_REQUEST, 8'd2, '0);
    push_request(OP_REQUEST, 8'd3, '0);
    push_request(OP_REQUEST, 8'd3, '0);
    push_request(OP_START, 8'd170, 64'h5555_5555_5555_5555);
    push_request(OP_FOUND, 8'd85, 64'hAAAA_AAAA_AAAA_AAAA);
    drain();

    // zero workers, stop disabled
    write_reg(REG_WORKERS, 64'd0);
    write_reg(REG_STOP1ST, 64'd0);
    end_writes();
    push_request(OP_START, 8'd4, '0);
    push_request(OP_REQUEST, 8'd4, '0);
    push_request(OP_FOUND, 8'd4, 64'd1);
    push_request(OP_FOUND, 8'd5, 64'd2);
    push_request(OP_REQUEST, 8'd5, '0);
    drain();

    // shuffle with seed zero, many workers
    calm = 1'b0;
    write_reg(REG_MODE, 64'd1);
    write_reg(REG_SEED, 64'd0);
    write_reg(REG_WORKERS, 64'd255);
    end_writes();
    push_request(OP_START, 8'd9, '0);
    push_random(30, 0, 6);
    drain();

    // shuffle with all-ones seed; run the table dry
    write_reg(REG_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_WORKERS, 64'd1);
    end_writes();
    push_request(OP_START, 8'd200, '0);
    for (int k = 0; k < 1298; k++)
      push_request(OP_REQUEST, 8'($urandom_range(1, 255)), '0);
    drain();

    // contiguous order over a filled table, starts allowed
    write_reg(REG_MODE, 64'd0);
    write_reg(REG_STOP1ST, 64'd1);
    write_reg(REG_WORKERS, 64'($urandom_range(1, 8)));
    end_writes();
    push_random(30, 8, 8);
    drain();

    // back to shuffled order without a new start
    calm = 1'b1;
    write_reg(REG_MODE, 64'd1);
    write_reg(REG_STOP1ST, 64'd0);
    end_writes();
    push_random(15, 0, 5);
    drain();
    calm = 1'b0;
    push_random(15, 0, 5);
    drain();
    repeat (20) @(posedge clk);

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(12 * 2_000_000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
